// File: rtl/rmud_pkg.sv
// Shared types and codes for the register-mapped unsigned divider.
// No dependencies; used by rmud_regs and the top level.
package rmud_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned ADDR_W = 2;

  // Word actions
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_CTRL = 2'd0;
  localparam logic [ADDR_W-1:0] ADDR_QUO  = 2'd1;
  localparam logic [ADDR_W-1:0] ADDR_REM  = 2'd2;

  // Control register bit positions
  localparam int unsigned CTRL_START_BIT = 0;
  localparam int unsigned CTRL_BUSY_BIT  = 1;
  localparam int unsigned CTRL_ERROR_BIT = 2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] reg_addr;
    logic [WORD_W-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic error;
  } status_t;

endpackage

// File: rtl/rmud_divstep.sv
// One restoring shift-subtract step of the divider.
// Pure combinational; depends on nothing else.
module rmud_divstep #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] quo_in,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] rem_out,
  output logic [DATA_WIDTH-1:0] quo_out
);

  logic [DATA_WIDTH:0] rem_ext;
  logic [DATA_WIDTH:0] div_ext;
  logic [DATA_WIDTH:0] diff;
  logic                ge;

  // Shift the next dividend bit (quotient MSB) into the partial remainder
  assign rem_ext = {rem_in, quo_in[DATA_WIDTH-1]};
  assign div_ext = {1'b0, divisor};
  assign diff    = rem_ext - div_ext;
  assign ge      = (rem_ext >= div_ext);

  assign rem_out = ge ? diff[DATA_WIDTH-1:0] : rem_ext[DATA_WIDTH-1:0];
  assign quo_out = {quo_in[DATA_WIDTH-2:0], ge};

endmodule

// File: rtl/rmud_regs.sv
// Register file and control of the divider: operand, quotient and
// remainder registers, start/busy/error flags. Uses rmud_pkg, rmud_divstep.
module rmud_regs #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  rmud_pkg::cmd_t               cmd,
  output logic [rmud_pkg::WORD_W-1:0]  read_value,
  output rmud_pkg::status_t            status
);

  localparam int unsigned STEP_W = $clog2(DATA_WIDTH + 1);

  logic                  start_r,  start_nxt;
  logic                  busy_r,   busy_nxt;
  logic                  error_r,  error_nxt;
  logic [DATA_WIDTH-1:0] dvd_r,    dvd_nxt;
  logic [DATA_WIDTH-1:0] dvs_r,    dvs_nxt;
  logic [DATA_WIDTH-1:0] quo_r,    quo_nxt;
  logic [DATA_WIDTH-1:0] rem_r,    rem_nxt;
  logic [STEP_W-1:0]     steps_r,  steps_nxt;

  logic [DATA_WIDTH-1:0] step_rem;
  logic [DATA_WIDTH-1:0] step_quo;
  logic                  new_start;

  rmud_divstep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_step (
    .rem_in (rem_r),
    .quo_in (quo_r),
    .divisor(dvs_r),
    .rem_out(step_rem),
    .quo_out(step_quo)
  );

  assign new_start = cmd.write_value[rmud_pkg::CTRL_START_BIT];

  always_comb begin
    start_nxt = start_r;
    busy_nxt  = busy_r;
    error_nxt = error_r;
    dvd_nxt   = dvd_r;
    dvs_nxt   = dvs_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    steps_nxt = steps_r;
    if (cmd_valid) begin
      unique case (cmd.action)
        rmud_pkg::ACT_WRITE: begin
          unique case (cmd.reg_addr)
            rmud_pkg::ADDR_CTRL: begin
              start_nxt = new_start;
              if (!new_start) begin
                error_nxt = 1'b0;
              end else if (!start_r && !busy_r) begin
                if (dvs_r == '0) begin
                  error_nxt = 1'b1;
                end else begin
                  error_nxt = 1'b0;
                  busy_nxt  = 1'b1;
                  quo_nxt   = dvd_r;
                  rem_nxt   = '0;
                  steps_nxt = STEP_W'(DATA_WIDTH);
                end
              end
            end
            rmud_pkg::ADDR_QUO: begin
              if (!busy_r) dvd_nxt = cmd.write_value[DATA_WIDTH-1:0];
            end
            rmud_pkg::ADDR_REM: begin
              if (!busy_r) dvs_nxt = cmd.write_value[DATA_WIDTH-1:0];
            end
            default: ;
          endcase
        end
        rmud_pkg::ACT_TICK: begin
          if (busy_r) begin
            quo_nxt   = step_quo;
            rem_nxt   = step_rem;
            steps_nxt = steps_r - STEP_W'(1);
            busy_nxt  = (steps_r != STEP_W'(1));
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b0;
      busy_r  <= 1'b0;
      error_r <= 1'b0;
      dvd_r   <= '0;
      dvs_r   <= '0;
      quo_r   <= '0;
      rem_r   <= '0;
      steps_r <= '0;
    end else begin
      start_r <= start_nxt;
      busy_r  <= busy_nxt;
      error_r <= error_nxt;
      dvd_r   <= dvd_nxt;
      dvs_r   <= dvs_nxt;
      quo_r   <= quo_nxt;
      rem_r   <= rem_nxt;
      steps_r <= steps_nxt;
    end
  end

  // Read data from the state before this word's update
  always_comb begin
    read_value = '0;
    if (cmd.action == rmud_pkg::ACT_READ) begin
      unique case (cmd.reg_addr)
        rmud_pkg::ADDR_CTRL: begin
          read_value[rmud_pkg::CTRL_START_BIT] = start_r;
          read_value[rmud_pkg::CTRL_BUSY_BIT]  = busy_r;
          read_value[rmud_pkg::CTRL_ERROR_BIT] = error_r;
        end
        rmud_pkg::ADDR_QUO: read_value = rmud_pkg::WORD_W'(quo_r);
        rmud_pkg::ADDR_REM: read_value = rmud_pkg::WORD_W'(rem_r);
        default:            read_value = '0;
      endcase
    end
  end

  assign status.start = start_r;
  assign status.busy  = busy_r;
  assign status.error = error_r;

endmodule

// File: rtl/register_mapped_unsigned_divider.sv
// Register-mapped unsigned divider, top level. Uses rmud_pkg, rmud_regs.
// An accepted word is held in the input register, then its read data in the result register.
// Throughput: one word per cycle while out_ready is high; a division needs DATA_WIDTH tick words,
// one restoring step per tick in the single shared step unit.
// Reset: synchronous, active low; clears flags, operands and results to 0.
module register_mapped_unsigned_divider #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [rmud_pkg::ACT_W-1:0]           in_action,
  input  logic [rmud_pkg::ADDR_W-1:0]          in_reg_addr,
  input  logic [rmud_pkg::WORD_W-1:0]          in_write_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [rmud_pkg::WORD_W-1:0]          out_read_value
);

  logic                          s1_valid_r;
  rmud_pkg::cmd_t                s1_cmd_r;
  logic                          out_valid_r;
  logic [rmud_pkg::WORD_W-1:0]   out_data_r;
  logic                          s1_adv;
  logic                          in_acc;
  logic [rmud_pkg::WORD_W-1:0]   rd_data;
  rmud_pkg::status_t             status;

  // Word moves from the input register into the result register
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  rmud_regs #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (s1_adv),
    .cmd       (s1_cmd_r),
    .read_value(rd_data),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r.action      <= in_action;
      s1_cmd_r.reg_addr    <= in_reg_addr;
      s1_cmd_r.write_value <= in_write_value;
    end
    if (s1_adv) begin
      out_data_r <= rd_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_data_r;

`ifndef SYNTH
  // A started division always clears error, and error is only set when idle
  a_busy_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.busy && status.error))
    else $error("busy and error set together");

  // Busy only drops on the last step of a tick word
  a_busy_fall_tick: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(status.busy) && $past(rst_n)) |->
      $past(s1_adv && (s1_cmd_r.action == rmud_pkg::ACT_TICK)))
    else $error("busy cleared without a tick");

  // Busy only rises on a control write
  a_busy_rise_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(status.busy) |->
      $past(s1_adv && (s1_cmd_r.action == rmud_pkg::ACT_WRITE)
            && (s1_cmd_r.reg_addr == rmud_pkg::ADDR_CTRL)))
    else $error("busy set without a control write");

  // A held input-stage word is not lost or overwritten
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_cmd_r)))
    else $error("stalled word dropped");
`endif

endmodule
